// ===== hw/rtl/recycling_id_allocator_unit_macros.svh =====
// Assertion macros used by the ID allocator port checker.
`ifndef RECYCLING_ID_ALLOCATOR_UNIT_MACROS_SVH
`define RECYCLING_ID_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define RIA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RIA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Delayed implication.
`define RIA_ASSERT_AFTER2(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ria_pkg.sv =====
// Package: field widths, request and status codes, controller command type.
package ria_pkg;

	localparam int FUNC_W   = 2;
	localparam int HANDLE_W = 32;
	localparam int ID_W     = 8;
	localparam int STATUS_W = 2;

	localparam int DEF_MAX_IDS     = 256;
	localparam int DEF_HANDLE_BITS = 32;

	localparam logic [FUNC_W-1:0] FUNC_REG     = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REG_UPD = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_UNREG   = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NULL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd3;

	localparam logic [ID_W-1:0] NONE_ID = 8'hFF;

	typedef struct packed {
		logic capture;  // item accepted this cycle
		logic hold;     // item in execute state, keep read addresses on it
		logic fire;     // execute: update state, load result register
	} ria_cmd_t;

endpackage

// ===== hw/rtl/ria_if.sv =====
// Request and response channel interfaces of the ID allocator.
interface ria_req_if;
	import ria_pkg::*;
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [HANDLE_W-1:0] handle;
	logic [ID_W-1:0]     target_id;
	modport source(output valid, func, handle, target_id, input ready);
	modport sink(input valid, func, handle, target_id, output ready);
endinterface

interface ria_rsp_if;
	import ria_pkg::*;
	logic                valid;
	logic                ready;
	logic [ID_W-1:0]     granted_id;
	logic [STATUS_W-1:0] status;
	modport source(output valid, granted_id, status, input ready);
	modport sink(input valid, granted_id, status, output ready);
endinterface

// ===== hw/rtl/recycling_id_allocator_unit.sv =====
// Top level of the recycling ID allocator: controller plus datapath.
// Channels: req (sink) carries func, handle and target_id; rsp (source)
// returns granted_id and status, one item per request. Both use valid/ready;
// an item moves on a clock edge with valid and ready high.
// Register requests hand out the oldest freed ID, else the next unused one,
// and store the handle; unregister checks the ID is live and recycles it.
// After acceptance the block enters its execute step; rsp.valid is registered
// and rises as that step ends, at once when the result register is empty. A new
// request waits until the last one leaves execute, as the table and FIFO reads
// are registered (a read step, then update and write-back). A result not taken
// holds the block in execute; the next request is still taken while a result waits.
// Reset (arst_n low) empties the FIFO and the fresh counter; table entries
// at or above the fresh mark count as never issued, so no clearing pass is run.
// rsp holds its item steady while rsp.ready is low.
module recycling_id_allocator_unit #(
	parameter int MAX_IDS     = ria_pkg::DEF_MAX_IDS,
	parameter int HANDLE_BITS = ria_pkg::DEF_HANDLE_BITS
) (
	input logic         clk,
	input logic         arst_n,
	ria_req_if.sink     req,
	ria_rsp_if.source   rsp
);
	import ria_pkg::*;

	ria_cmd_t cmd;

	ria_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	ria_dp #(.MAX_IDS(MAX_IDS), .HANDLE_BITS(HANDLE_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.func       (req.func),
		.handle     (req.handle),
		.target_id  (req.target_id),
		.granted_id (rsp.granted_id),
		.status     (rsp.status)
	);
endmodule

// ===== hw/rtl/ria_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ria_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/ria_ctrl.sv =====
// Controller: accept / execute sequencing and result valid.
module ria_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ria_pkg::ria_cmd_t cmd
);
	import ria_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic fire;

	// execute only once the result register is free or being emptied
	assign fire      = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	assign cmd.capture = in_valid && in_ready;
	assign cmd.hold    = (state_q == S_EXEC);
	assign cmd.fire    = fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// ===== hw/rtl/ria_dp.sv =====
// Datapath: free-ID FIFO, handle table, fresh counter and result register.
module ria_dp #(
	parameter int MAX_IDS     = ria_pkg::DEF_MAX_IDS,
	parameter int HANDLE_BITS = ria_pkg::DEF_HANDLE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ria_pkg::ria_cmd_t              cmd,
	input  logic [ria_pkg::FUNC_W-1:0]     func,
	input  logic [ria_pkg::HANDLE_W-1:0]   handle,
	input  logic [ria_pkg::ID_W-1:0]       target_id,
	output logic [ria_pkg::ID_W-1:0]       granted_id,
	output logic [ria_pkg::STATUS_W-1:0]   status
);
	import ria_pkg::*;

	localparam int IdW  = $clog2(MAX_IDS);
	localparam int CntW = $clog2(MAX_IDS + 1);
	localparam int TblW = HANDLE_BITS + 1;

	// captured item
	logic [FUNC_W-1:0]      func_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [ID_W-1:0]        target_q;

	// FIFO and allocation state
	logic [IdW-1:0]  head_q, head_d;
	logic [IdW-1:0]  tail_q, tail_d;
	logic [CntW-1:0] count_q, count_d;
	logic [CntW-1:0] fresh_q, fresh_d;

	logic [ID_W-1:0]     gid_q, gid_d;
	logic [STATUS_W-1:0] status_q, status_d;

	logic [IdW-1:0]  fifo_rdata;
	logic            fifo_we;
	logic [TblW-1:0] tbl_rdata;
	logic [TblW-1:0] tbl_wdata;
	logic [IdW-1:0]  tbl_waddr;
	logic [IdW-1:0]  tbl_raddr;
	logic            tbl_we;

	logic [IdW-1:0] tgt_idx;
	logic           tgt_live;
	logic [IdW-1:0] grant_id;
	logic           grant;

	assign tgt_idx   = IdW'(32'(target_q));
	assign tbl_raddr = cmd.hold ? tgt_idx : IdW'(32'(target_id));

	// table entries below the fresh mark were written when issued
	assign tgt_live = (32'(target_q) < MAX_IDS) && (32'(target_q) < 32'(fresh_q))
		&& (tbl_rdata[HANDLE_BITS-1:0] != '0);

	ria_ram #(.WIDTH(IdW), .DEPTH(MAX_IDS)) u_fifo_ram (
		.clk   (clk),
		.we    (fifo_we && cmd.fire),
		.waddr (tail_q),
		.wdata (tgt_idx),
		.raddr (head_q),
		.rdata (fifo_rdata)
	);

	// handle in the low bits, updateable mark on top
	ria_ram #(.WIDTH(TblW), .DEPTH(MAX_IDS)) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we && cmd.fire),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		fresh_d   = fresh_q;
		fifo_we   = 1'b0;
		tbl_we    = 1'b0;
		tbl_waddr = tgt_idx;
		tbl_wdata = '0;
		grant     = 1'b0;
		grant_id  = fifo_rdata;
		gid_d     = NONE_ID;
		status_d  = STATUS_BAD;
		case (func_q)
			FUNC_REG, FUNC_REG_UPD: begin
				if (handle_q == '0) begin
					status_d = STATUS_NULL;
				end else if (count_q != '0) begin
					grant    = 1'b1;
					grant_id = fifo_rdata;
					head_d   = (32'(head_q) == MAX_IDS - 1) ? '0 : IdW'(32'(head_q) + 1);
					count_d  = count_q - CntW'(1);
				end else if (32'(fresh_q) < MAX_IDS) begin
					grant    = 1'b1;
					grant_id = IdW'(fresh_q);
					fresh_d  = fresh_q + CntW'(1);
				end else begin
					status_d = STATUS_FULL;
				end
				if (grant) begin
					tbl_we    = 1'b1;
					tbl_waddr = grant_id;
					tbl_wdata = {func_q == FUNC_REG_UPD, handle_q};
					gid_d     = ID_W'(32'(grant_id));
					status_d  = STATUS_OK;
				end
			end
			FUNC_UNREG: begin
				gid_d = target_q;
				if (tgt_live) begin
					tbl_we   = 1'b1;
					status_d = STATUS_OK;
					if (32'(count_q) < MAX_IDS) begin
						fifo_we = 1'b1;
						tail_d  = (32'(tail_q) == MAX_IDS - 1) ? '0 : IdW'(32'(tail_q) + 1);
						count_d = count_q + CntW'(1);
					end
				end
			end
			default: begin
				gid_d    = NONE_ID;
				status_d = STATUS_BAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			fresh_q <= '0;
		end else if (cmd.fire) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			fresh_q <= fresh_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q   <= func;
			handle_q <= HANDLE_BITS'(handle);
			target_q <= target_id;
		end
		if (cmd.fire) begin
			gid_q    <= gid_d;
			status_q <= status_d;
		end
	end

	assign granted_id = gid_q;
	assign status     = status_q;
endmodule

// ===== hw/rtl/ria_checker.sv =====
// Port-level checker for the ID allocator, bound to the top level.
`include "recycling_id_allocator_unit_macros.svh"

module ria_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [ria_pkg::ID_W-1:0]     rsp_granted_id,
	input logic [ria_pkg::STATUS_W-1:0] rsp_status
);
	import ria_pkg::*;

	`RIA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp item dropped while stalled")
	`RIA_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken during execute")
	`RIA_ASSERT_AFTER2(a_latency, req_valid && req_ready && !rsp_valid, rsp_valid, "result late")
	`RIA_ASSERT_NOW(a_null_id, rsp_valid && rsp_status == STATUS_NULL, rsp_granted_id == NONE_ID, "null status with an ID")
	`RIA_ASSERT_NOW(a_full_id, rsp_valid && rsp_status == STATUS_FULL, rsp_granted_id == NONE_ID, "full status with an ID")
endmodule

bind recycling_id_allocator_unit ria_checker u_ria_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_granted_id (rsp.granted_id),
	.rsp_status     (rsp.status)
);

// ===== bench/recycling_id_allocator_unit_chk.sv =====
`timescale 1ns / 1ps
// Checker for the ID allocator: models the allocation state and compares every result item.
module recycling_id_allocator_unit_chk
	import ria_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ria_req_if   req,
	ria_rsp_if   rsp,
	output int   mismatches,
	output int   outstanding
);

	localparam int ID_COUNT = DEF_MAX_IDS;

	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic [STATUS_W-1:0] status;
	} grant_t;

	// shadow of the allocator: recycled-ID FIFO, fresh counter, owner table, marks
	logic [ID_W-1:0]     recycled_ids [ID_COUNT];
	logic [ID_W-1:0]     recycle_head;
	logic [ID_W-1:0]     recycle_tail;
	logic [8:0]          recycle_count;
	logic [8:0]          fresh_mark;
	logic [HANDLE_W-1:0] owner_handle [ID_COUNT];
	bit                  updateable   [ID_COUNT];

	grant_t grants_due[$];

	function automatic grant_t allocate(input logic [FUNC_W-1:0] f,
			input logic [HANDLE_W-1:0] h, input logic [ID_W-1:0] t);
		grant_t          g;
		logic [ID_W-1:0] id;
		g.id     = NONE_ID;
		g.status = STATUS_BAD;
		case (f)
			FUNC_REG, FUNC_REG_UPD: begin
				if (h == '0) begin
					g.status = STATUS_NULL;
				end else if (recycle_count != 0 || fresh_mark < ID_COUNT) begin
					// oldest freed ID wins over a fresh one
					if (recycle_count != 0) begin
						id = recycled_ids[recycle_head];
						recycle_head++;
						recycle_count--;
					end else begin
						id = fresh_mark[ID_W-1:0];
						fresh_mark++;
					end
					owner_handle[id] = h;
					if (f == FUNC_REG_UPD)
						updateable[id] = 1'b1;
					g.id     = id;
					g.status = STATUS_OK;
				end else begin
					g.status = STATUS_FULL;
				end
			end
			FUNC_UNREG: begin
				g.id = t;
				if (t < fresh_mark && owner_handle[t] != '0) begin
					owner_handle[t] = '0;
					updateable[t]   = 1'b0;
					if (recycle_count < ID_COUNT) begin
						recycled_ids[recycle_tail] = t;
						recycle_tail++;
						recycle_count++;
					end
					g.status = STATUS_OK;
				end
			end
			default: ;
		endcase
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			recycle_head  = '0;
			recycle_tail  = '0;
			recycle_count = '0;
			fresh_mark    = '0;
			for (int i = 0; i < ID_COUNT; i++) begin
				owner_handle[i] = '0;
				updateable[i]   = 1'b0;
			end
			grants_due.delete();
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (grants_due.size() == 0) begin
					$display("%0t: unexpected result item id %0d status %0d",
						$time, rsp.granted_id, rsp.status);
					mismatches++;
				end else begin
					want = grants_due.pop_front();
					if (rsp.granted_id !== want.id) begin
						$display("%0t: granted_id expected %0d got %0d",
							$time, want.id, rsp.granted_id);
						mismatches++;
					end
					if (rsp.status !== want.status) begin
						$display("%0t: status expected %0d got %0d",
							$time, want.status, rsp.status);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready)
				grants_due = {grants_due, allocate(req.func, req.handle, req.target_id)};
			outstanding <= grants_due.size();
		end
	end

endmodule

// ===== bench/recycling_id_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top of the ID allocator: clock, reset, request and response traffic, verdict.
module recycling_id_allocator_unit_tb;
	import ria_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int LONG_HOLD   = 300;
	localparam int STALL_LIMIT = 3000;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   pending;
	int   quiet_cycles = 0;
	int   full_hits = 0;
	bit   no_idle = 1'b0;
	bit   hold_request = 1'b0;

	logic [FUNC_W-1:0] issued_funcs[$];
	logic [ID_W-1:0]   live_ids[$];

	ria_req_if req_ch();
	ria_rsp_if rsp_ch();

	recycling_id_allocator_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	recycling_id_allocator_unit_chk u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [HANDLE_W-1:0] random_handle();
		logic [HANDLE_W-1:0] h;
		h = $urandom;
		return (h == '0) ? HANDLE_W'(1) : h;
	endfunction

	// live ID to release; falls back to a random target when none is known
	function automatic logic [ID_W-1:0] pick_release_target();
		int              k;
		logic [ID_W-1:0] id;
		if (live_ids.size() == 0)
			return ID_W'($urandom_range(0, 255));
		k  = $urandom_range(0, live_ids.size() - 1);
		id = live_ids[k];
		live_ids.delete(k);
		return id;
	endfunction

	task automatic send_req(input logic [FUNC_W-1:0] f, input logic [HANDLE_W-1:0] h,
			input logic [ID_W-1:0] t);
		int gap;
		req_ch.valid     <= 1'b1;
		req_ch.func      <= f;
		req_ch.handle    <= h;
		req_ch.target_id <= t;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		issued_funcs = {issued_funcs, f};
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic send_register();
		send_req(($urandom_range(0, 1) != 0) ? FUNC_REG_UPD : FUNC_REG, random_handle(),
			ID_W'($urandom));
	endtask

	// mostly well-formed traffic with a little noise mixed in
	task automatic send_mixed(input int reg_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			case ($urandom_range(0, 2))
				0: send_req(FUNC_UNUSED, HANDLE_W'($urandom), ID_W'($urandom));
				1: send_req(FUNC_UNREG, HANDLE_W'($urandom), ID_W'($urandom));
				default: send_req(($urandom_range(0, 1) != 0) ? FUNC_REG_UPD : FUNC_REG,
					'0, ID_W'($urandom));
			endcase
		end else if (r < 6 + reg_pct) begin
			send_register();
		end else begin
			send_req(FUNC_UNREG, HANDLE_W'($urandom), pick_release_target());
		end
	endtask

	// response side bookkeeping: collects granted IDs for later release, counts full results
	always @(posedge clk) begin
		logic [FUNC_W-1:0] f;
		if (arst_n && rsp_ch.valid && rsp_ch.ready && issued_funcs.size() != 0) begin
			f = issued_funcs.pop_front();
			if (rsp_ch.status == STATUS_FULL)
				full_hits++;
			if ((f == FUNC_REG || f == FUNC_REG_UPD) && rsp_ch.status == STATUS_OK)
				live_ids = {live_ids, rsp_ch.granted_id};
		end
	end

	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (req_ch.valid && req_ch.ready) ||
				(rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[recycling_id_allocator_unit] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result receiver: random stalls, idle-free stretches, one long hold on request
	initial begin
		int  hold_left;
		int  gap_left;
		bit  rdy;
		hold_left = 0;
		gap_left  = 0;
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = LONG_HOLD;
			end
			if (hold_left > 0) begin
				rdy = 1'b0;
				hold_left--;
			end else if (no_idle) begin
				rdy = 1'b1;
			end else if (gap_left > 0) begin
				rdy = 1'b0;
				gap_left--;
			end else begin
				rdy = 1'b1;
				if ($urandom_range(0, 3) == 0)
					gap_left = pick_gap();
			end
			rsp_ch.ready <= rdy;
			@(posedge clk);
		end
	end

	initial begin
		req_ch.valid     <= 1'b0;
		req_ch.func      <= FUNC_REG;
		req_ch.handle    <= '0;
		req_ch.target_id <= '0;
		arst_n           <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: null handle, extremes, dead and never-issued IDs, unused code, recycling
		send_req(FUNC_REG, '0, '0);
		send_req(FUNC_REG, '1, '1);
		send_req(FUNC_REG_UPD, HANDLE_W'(1), '0);
		send_req(FUNC_UNREG, '1, NONE_ID);
		send_req(FUNC_UNREG, '0, ID_W'(2));
		send_req(FUNC_UNREG, '0, ID_W'(0));
		send_req(FUNC_UNREG, '1, ID_W'(0));
		send_req(FUNC_UNUSED, '1, '1);
		send_req(FUNC_UNUSED, '0, '0);
		send_req(FUNC_REG_UPD, 32'h8000_0000, '0);
		send_req(FUNC_REG_UPD, '0, '1);
		send_req(FUNC_UNREG, '0, ID_W'(1));
		send_req(FUNC_UNREG, '0, ID_W'(0));
		send_req(FUNC_REG, 32'h5A5A_5A5A, 8'hA5);
		send_req(FUNC_REG, 32'hA5A5_A5A5, 8'h5A);
		send_req(FUNC_UNREG, '0, ID_W'(1));
		send_req(FUNC_UNREG, '0, ID_W'(0));
		drain_results();
		live_ids.delete();

		// random churn at moderate occupancy
		repeat (300) send_mixed(55);
		drain_results();

		// fill up until the table reports full, with one long response hold on the way
		repeat (100) send_register();
		hold_request = 1'b1;
		no_idle      = 1'b1;
		repeat (40) send_register();
		no_idle = 1'b0;
		while (full_hits < 6)
			send_register();

		// churn near the full boundary, first stretch without idling
		no_idle = 1'b1;
		repeat (150) send_mixed(47);
		no_idle = 1'b0;
		repeat (350) send_mixed(47);
		drain_results();

		// release everything, then light traffic over the wrapped FIFO
		while (live_ids.size() != 0)
			send_req(FUNC_UNREG, HANDLE_W'($urandom), pick_release_target());
		repeat (60) send_mixed(60);
		repeat (5) send_req(FUNC_UNREG, HANDLE_W'($urandom), ID_W'($urandom));

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("[recycling_id_allocator_unit] OK");
		else
			$display("[recycling_id_allocator_unit] ERROR");
		$finish;
	end

endmodule
